// ===== hw/rtl/pflc_pkg.sv =====
// ----------------------------------------------------------------------------
// pflc_pkg
// Types, codes and constants shared by the pump fill level controller.
// ----------------------------------------------------------------------------
package pflc_pkg;

	typedef enum logic [1:0] {
		PH_STANDBY   = 2'd0,
		PH_FILLING   = 2'd1,
		PH_COUNTDOWN = 2'd2,
		PH_ALARM     = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		CAUSE_NONE  = 2'd0,
		CAUSE_ALARM = 2'd1,
		CAUSE_DONE  = 2'd2
	} cause_t;

	typedef enum logic [1:0] {
		SEL_KEEP = 2'd0,
		SEL_ZERO = 2'd1,
		SEL_LOAD = 2'd2,
		SEL_CALC = 2'd3
	} secs_sel_t;

	localparam logic [7:0]  MIN_TIMEOUT_MINUTES   = 8'd1;
	localparam logic [7:0]  MAX_TIMEOUT_MINUTES   = 8'd240;
	localparam logic [7:0]  RESET_TIMEOUT_MINUTES = 8'd5;
	localparam logic [13:0] SEC_PER_MIN           = 14'd60;
	localparam logic [23:0] MS_PER_MIN            = 24'd60000;
	localparam logic [31:0] MS_PER_SEC            = 32'd1000;
	localparam logic [13:0] SECONDS_MAX           = 14'd16383;

	// floor(x / 1000) for x < 2^24 as (x * RECIP_MULT) >> RECIP_SHIFT
	localparam int          REM_W       = 24;
	localparam int          RECIP_SHIFT = 34;
	localparam logic [24:0] RECIP_MULT  =
		25'(((64'd1 << RECIP_SHIFT) + 64'(MS_PER_SEC) - 64'd1) / 64'(MS_PER_SEC));
	localparam logic [31:0] SAT_LIMIT   = (32'(SECONDS_MAX) + 32'd1) * MS_PER_SEC;

	typedef struct packed {
		logic        pump_on;
		logic        alarm_on;
		phase_t      phase;
		cause_t      stop_cause;
		logic        pump_started;
		logic        pump_stopped;
		logic [31:0] fill_total;
		logic [31:0] alarm_total;
	} stat_t;

	typedef struct packed {
		stat_t       stat;
		secs_sel_t   secs_sel;
		logic [13:0] secs_load;
		logic [31:0] rem_bias;
	} ctrl_res_t;

	function automatic logic [7:0] clamp_minutes(input logic [7:0] mins);
		logic [7:0] m;
		begin
			m = mins;
			if (m < MIN_TIMEOUT_MINUTES) m = MIN_TIMEOUT_MINUTES;
			if (m > MAX_TIMEOUT_MINUTES) m = MAX_TIMEOUT_MINUTES;
			return m;
		end
	endfunction

	function automatic logic [13:0] topoff_sec(input logic [7:0] mins);
		return 14'(clamp_minutes(mins)) * SEC_PER_MIN;
	endfunction

	function automatic logic [23:0] topoff_ms(input logic [7:0] mins);
		return 24'(clamp_minutes(mins)) * MS_PER_MIN;
	endfunction

endpackage

// ===== hw/rtl/pflc_tick_if.sv =====
// ----------------------------------------------------------------------------
// pflc_tick_if
// Input channel: one tick with time and float-switch levels per item.
// ----------------------------------------------------------------------------
interface pflc_tick_if;
	logic        valid;
	logic        ready;
	logic [31:0] now_ms;
	logic        lower_wet;
	logic        upper_wet;

	modport source (output valid, output now_ms, output lower_wet, output upper_wet,
		input ready);
	modport sink (input valid, input now_ms, input lower_wet, input upper_wet,
		output ready);
endinterface

// ===== hw/rtl/pflc_status_if.sv =====
// ----------------------------------------------------------------------------
// pflc_status_if
// Output channel: controller status after each tick.
// ----------------------------------------------------------------------------
interface pflc_status_if;
	logic        valid;
	logic        ready;
	logic        pump_on;
	logic        alarm_on;
	logic [1:0]  phase;
	logic [13:0] remaining_seconds;
	logic [1:0]  stop_cause;
	logic        pump_started;
	logic        pump_stopped;
	logic [31:0] fill_total_out;
	logic [31:0] alarm_total_out;

	modport source (output valid, output pump_on, output alarm_on, output phase,
		output remaining_seconds, output stop_cause, output pump_started,
		output pump_stopped, output fill_total_out, output alarm_total_out,
		input ready);
	modport sink (input valid, input pump_on, input alarm_on, input phase,
		input remaining_seconds, input stop_cause, input pump_started,
		input pump_stopped, input fill_total_out, input alarm_total_out,
		output ready);
endinterface

// ===== hw/rtl/pflc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pflc_ctrl
// Fill state machine, deadline and counters; steps once per advancing item.
// ----------------------------------------------------------------------------
module pflc_ctrl import pflc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        adv,
	input  logic [31:0] now_ms,
	input  logic        lower_wet,
	input  logic        upper_wet,
	output ctrl_res_t   res
);

	logic [13:0] clamp_sec_q;
	logic [23:0] clamp_ms_q;

	phase_t      phase_q, phase_n;
	logic        pump_q, pump_n;
	logic        alarm_q, alarm_n;
	logic [31:0] deadline_q, deadline_n;
	logic [13:0] topoff_sec_q, topoff_sec_n;
	logic [23:0] topoff_ms_q, topoff_ms_n;
	cause_t      cause_q, cause_n;
	logic [31:0] fill_total_q, fill_total_n;
	logic [31:0] alarm_total_q, alarm_total_n;

	logic        started, stopped;
	secs_sel_t   sel;
	logic [31:0] past;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamp_sec_q <= topoff_sec(RESET_TIMEOUT_MINUTES);
			clamp_ms_q  <= topoff_ms(RESET_TIMEOUT_MINUTES);
		end else if (cfg_we) begin
			clamp_sec_q <= topoff_sec(cfg_wdata);
			clamp_ms_q  <= topoff_ms(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_STANDBY;
			pump_q        <= 1'b0;
			alarm_q       <= 1'b0;
			deadline_q    <= '0;
			topoff_sec_q  <= '0;
			topoff_ms_q   <= '0;
			cause_q       <= CAUSE_NONE;
			fill_total_q  <= '0;
			alarm_total_q <= '0;
		end else if (adv) begin
			phase_q       <= phase_n;
			pump_q        <= pump_n;
			alarm_q       <= alarm_n;
			deadline_q    <= deadline_n;
			topoff_sec_q  <= topoff_sec_n;
			topoff_ms_q   <= topoff_ms_n;
			cause_q       <= cause_n;
			fill_total_q  <= fill_total_n;
			alarm_total_q <= alarm_total_n;
		end
	end

	assign past = now_ms - deadline_q;

	always_comb begin
		phase_n       = phase_q;
		pump_n        = pump_q;
		alarm_n       = alarm_q;
		deadline_n    = deadline_q;
		topoff_sec_n  = topoff_sec_q;
		topoff_ms_n   = topoff_ms_q;
		cause_n       = cause_q;
		fill_total_n  = fill_total_q;
		alarm_total_n = alarm_total_q;
		started       = 1'b0;
		stopped       = 1'b0;
		sel           = SEL_KEEP;

		if (alarm_q) begin
			if (!lower_wet && !upper_wet) begin
				alarm_n = 1'b0;
				phase_n = PH_STANDBY;
			end
		end else if (upper_wet) begin
			alarm_total_n = alarm_total_q + 32'd1;
			phase_n       = PH_ALARM;
			pump_n        = 1'b0;
			alarm_n       = 1'b1;
			cause_n       = CAUSE_ALARM;
			sel           = SEL_ZERO;
			topoff_sec_n  = '0;
			topoff_ms_n   = '0;
			stopped       = 1'b1;
		end else if (!pump_q) begin
			sel          = SEL_ZERO;
			deadline_n   = '0;
			topoff_sec_n = clamp_sec_q;
			topoff_ms_n  = clamp_ms_q;
			phase_n      = PH_STANDBY;
			if (lower_wet) begin
				pump_n       = 1'b1;
				cause_n      = CAUSE_NONE;
				phase_n      = PH_FILLING;
				fill_total_n = fill_total_q + 32'd1;
				started      = 1'b1;
			end
		end else if (phase_q == PH_FILLING) begin
			if (!lower_wet) begin
				if (topoff_sec_q == '0) begin
					topoff_sec_n = clamp_sec_q;
					topoff_ms_n  = clamp_ms_q;
				end
				phase_n    = PH_COUNTDOWN;
				sel        = SEL_LOAD;
				deadline_n = now_ms + 32'(topoff_ms_n);
			end
		end else if (phase_q == PH_COUNTDOWN) begin
			if (lower_wet) begin
				phase_n    = PH_FILLING;
				sel        = SEL_ZERO;
				deadline_n = '0;
			end else if (!past[31]) begin
				pump_n     = 1'b0;
				phase_n    = PH_STANDBY;
				sel        = SEL_ZERO;
				deadline_n = '0;
				cause_n    = CAUSE_DONE;
				stopped    = 1'b1;
			end else begin
				sel = SEL_CALC;
			end
		end

		res.stat.pump_on      = pump_n;
		res.stat.alarm_on     = alarm_n;
		res.stat.phase        = phase_n;
		res.stat.stop_cause   = cause_n;
		res.stat.pump_started = started;
		res.stat.pump_stopped = stopped;
		res.stat.fill_total   = fill_total_n;
		res.stat.alarm_total  = alarm_total_n;
		res.secs_sel          = sel;
		res.secs_load         = topoff_sec_n;
		res.rem_bias          = deadline_q - now_ms + (MS_PER_SEC - 32'd1);
	end

endmodule

// ===== hw/rtl/pflc_secs.sv =====
// ----------------------------------------------------------------------------
// pflc_secs
// Remaining top-off seconds: kept, zeroed, loaded, or a ceiling divide by 1000 with saturation.
// ----------------------------------------------------------------------------
module pflc_secs import pflc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  ctrl_res_t   res,
	output logic [13:0] secs_q
);

	logic [48:0] prod;
	logic [13:0] secs_n;

	assign prod = 49'(res.rem_bias[REM_W-1:0]) * 49'(RECIP_MULT);

	always_comb begin
		case (res.secs_sel)
			SEL_KEEP: secs_n = secs_q;
			SEL_ZERO: secs_n = '0;
			SEL_LOAD: secs_n = res.secs_load;
			SEL_CALC: begin
				if (res.rem_bias >= SAT_LIMIT) secs_n = SECONDS_MAX;
				else secs_n = prod[RECIP_SHIFT +: 14];
			end
			default: secs_n = secs_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			secs_q <= '0;
		end else if (adv) begin
			secs_q <= secs_n;
		end
	end

endmodule

// ===== hw/rtl/pump_fill_level_controller.sv =====
// ----------------------------------------------------------------------------
// pump_fill_level_controller
// Float-switch pump controller with top-off countdown and overflow alarm.
// ----------------------------------------------------------------------------
// Takes one tick per clock while the output is not stalled, and returns one
// status item per tick. A tick is registered into stage s1, the fill state
// machine and deadline arithmetic step as it moves on into stage s2, and the
// remaining seconds are divided out by a constant multiply as it moves into
// the output register. While a status waits, ticks are still taken until
// stages s1 and s2 are full.
// The timeout register is clamped to 1..240 minutes when written.
module pump_fill_level_controller import pflc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [7:0]    cfg_wdata,
	pflc_tick_if.sink     tick,
	pflc_status_if.source status
);

	logic        vld_s1, vld_s2, out_vld_q;
	logic [31:0] now_ms_s1;
	logic        lower_wet_s1, upper_wet_s1;
	ctrl_res_t   res, ctrl_s2;
	stat_t       out_stat_q;
	logic [13:0] secs_q;
	logic        out_adv, s2_adv, in_adv;

	assign out_adv    = vld_s2 && (!out_vld_q || status.ready);
	assign s2_adv     = vld_s1 && (!vld_s2 || out_adv);
	assign tick.ready = !vld_s1 || s2_adv;
	assign in_adv     = tick.valid && tick.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (tick.ready) vld_s1 <= tick.valid;
			if (!vld_s2 || out_adv) vld_s2 <= s2_adv;
			if (!out_vld_q || status.ready) out_vld_q <= out_adv;
		end
	end

	always_ff @(posedge clk) begin
		if (in_adv) begin
			now_ms_s1    <= tick.now_ms;
			lower_wet_s1 <= tick.lower_wet;
			upper_wet_s1 <= tick.upper_wet;
		end
		if (s2_adv) ctrl_s2 <= res;
		if (out_adv) out_stat_q <= ctrl_s2.stat;
	end

	pflc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.adv       (s2_adv),
		.now_ms    (now_ms_s1),
		.lower_wet (lower_wet_s1),
		.upper_wet (upper_wet_s1),
		.res       (res)
	);

	pflc_secs u_secs (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (out_adv),
		.res    (ctrl_s2),
		.secs_q (secs_q)
	);

	assign status.valid             = out_vld_q;
	assign status.pump_on           = out_stat_q.pump_on;
	assign status.alarm_on          = out_stat_q.alarm_on;
	assign status.phase             = out_stat_q.phase;
	assign status.remaining_seconds = secs_q;
	assign status.stop_cause        = out_stat_q.stop_cause;
	assign status.pump_started      = out_stat_q.pump_started;
	assign status.pump_stopped      = out_stat_q.pump_stopped;
	assign status.fill_total_out    = out_stat_q.fill_total;
	assign status.alarm_total_out   = out_stat_q.alarm_total;

endmodule

// ===== bench/tb_pump_fill_level_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pump_fill_level_controller
// Drives ticks with random gaps and output stalls, predicts every status item
// from a local model of the fill state machine, and compares field by field.
// Covers fill and top-off, deadline wrap and time jumps, the overflow alarm,
// timeout register extremes, and a long output stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_pump_fill_level_controller;
	import pflc_pkg::*;

	localparam logic [31:0] MS_PER_S     = 32'd1000;
	localparam logic [31:0] ROUND_UP_MS  = 32'd999;
	localparam logic [13:0] S_PER_MIN    = 14'd60;
	localparam logic [13:0] SECS_CAP     = 14'h3FFF;
	localparam int          IDLE_MAX     = 19;
	localparam int          RX_HOLD      = 200;
	localparam int          RANDOM_TICKS = 220;
	localparam int          STALL_LIMIT  = 2000;
	localparam int          TAIL_CYCLES  = 12;

	typedef struct {
		logic        pump_on;
		logic        alarm_on;
		phase_t      phase;
		logic [13:0] secs;
		cause_t      cause;
		logic        started;
		logic        stopped;
		logic [31:0] fills;
		logic [31:0] alarms;
	} status_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [7:0] cfg_wdata;

	pflc_tick_if   tick_ch ();
	pflc_status_if status_ch ();

	pump_fill_level_controller u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.tick      (tick_ch),
		.status    (status_ch)
	);

	// Controller state as predicted
	logic [7:0]  timeout_minutes;
	phase_t      cur_phase;
	logic        pump_active;
	logic        alarm_active;
	logic [31:0] end_time_ms;
	logic [13:0] run_s;
	logic [13:0] left_s;
	cause_t      cause_q;
	logic [31:0] fill_count;
	logic [31:0] alarm_count;

	status_t     pending_status[$];
	int          mismatch_count;
	int          status_index;
	int          idle_cycles;
	int          rx_hold_cycles;
	bit          tx_eager;
	bit          rx_eager;
	logic [31:0] tick_time;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [13:0] topoff_run_s();
		logic [7:0] m;
		m = timeout_minutes;
		if (m < MIN_TIMEOUT_MINUTES) m = MIN_TIMEOUT_MINUTES;
		if (m > MAX_TIMEOUT_MINUTES) m = MAX_TIMEOUT_MINUTES;
		return 14'(m) * S_PER_MIN;
	endfunction

	function automatic status_t advance_controller(input logic [31:0] now, input logic lower,
		input logic upper);
		status_t     s;
		logic [31:0] past;
		logic [31:0] rem;
		logic [31:0] secs;
		s.started = 1'b0;
		s.stopped = 1'b0;
		if (alarm_active) begin
			if (!lower && !upper) begin
				alarm_active = 1'b0;
				cur_phase = PH_STANDBY;
			end
		end else if (upper) begin
			alarm_count = alarm_count + 32'd1;
			cur_phase = PH_ALARM;
			pump_active = 1'b0;
			alarm_active = 1'b1;
			cause_q = CAUSE_ALARM;
			left_s = '0;
			run_s = '0;
			s.stopped = 1'b1;
		end else if (!pump_active) begin
			left_s = '0;
			end_time_ms = '0;
			run_s = topoff_run_s();
			cur_phase = PH_STANDBY;
			if (lower) begin
				pump_active = 1'b1;
				cause_q = CAUSE_NONE;
				cur_phase = PH_FILLING;
				fill_count = fill_count + 32'd1;
				s.started = 1'b1;
			end
		end else if (cur_phase == PH_FILLING) begin
			if (!lower) begin
				if (run_s == '0) run_s = topoff_run_s();
				cur_phase = PH_COUNTDOWN;
				left_s = run_s;
				end_time_ms = now + 32'(run_s) * MS_PER_S;
			end
		end else if (cur_phase == PH_COUNTDOWN) begin
			if (lower) begin
				cur_phase = PH_FILLING;
				left_s = '0;
				end_time_ms = '0;
			end else begin
				past = now - end_time_ms;
				if (past < 32'h8000_0000) begin
					pump_active = 1'b0;
					cur_phase = PH_STANDBY;
					left_s = '0;
					end_time_ms = '0;
					cause_q = CAUSE_DONE;
					s.stopped = 1'b1;
				end else begin
					rem = end_time_ms - now;
					secs = (rem + ROUND_UP_MS) / MS_PER_S;
					left_s = (secs > 32'(SECS_CAP)) ? SECS_CAP : secs[13:0];
				end
			end
		end
		s.pump_on = pump_active;
		s.alarm_on = alarm_active;
		s.phase = cur_phase;
		s.secs = left_s;
		s.cause = cause_q;
		s.fills = fill_count;
		s.alarms = alarm_count;
		return s;
	endfunction

	task automatic send_tick(input logic [31:0] now, input logic lower, input logic upper);
		int gap;
		gap = tx_eager ? 0 : $urandom_range(0, IDLE_MAX);
		@(negedge clk);
		if (gap > 0) begin
			tick_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.now_ms <= now;
		tick_ch.lower_wet <= lower;
		tick_ch.upper_wet <= upper;
		do @(posedge clk); while (tick_ch.ready !== 1'b1);
		tick_time = now;
		pending_status.push_back(advance_controller(now, lower, upper));
	endtask

	task automatic drain_status();
		@(negedge clk);
		tick_ch.valid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [7:0] minutes);
		drain_status();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= minutes;
		@(negedge clk);
		cfg_we <= 1'b0;
		timeout_minutes = minutes;
	endtask

	task automatic random_tick();
		logic [31:0] now;
		logic [31:0] rem;
		logic        lower;
		logic        upper;
		now = tick_time + $urandom_range(0, 3000);
		lower = 1'b0;
		upper = ($urandom_range(0, 99) < 3);
		if ($urandom_range(0, 99) < 6) begin
			now = $urandom;
			lower = 1'($urandom_range(0, 1));
			upper = 1'($urandom_range(0, 1));
		end else begin
			case (cur_phase)
				PH_STANDBY: lower = 1'($urandom_range(0, 1));
				PH_FILLING: lower = ($urandom_range(0, 4) < 3);
				PH_COUNTDOWN: begin
					lower = ($urandom_range(0, 11) == 0);
					rem = end_time_ms - tick_time;
					if ($urandom_range(0, 2) == 0)
						now = end_time_ms + 32'($urandom_range(0, 2)) - 32'd1;
					else if (rem < 32'h8000_0000)
						now = tick_time + $urandom_range(0, rem);
				end
				PH_ALARM: begin
					lower = ($urandom_range(0, 2) == 0);
					upper = ($urandom_range(0, 2) == 0);
				end
				default: lower = 1'b0;
			endcase
		end
		send_tick(now, lower, upper);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("status %0d %s: expected %0h, got %0h", status_index, name, want, got);
		end
	endtask

	task automatic check_status();
		status_t s;
		if (pending_status.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("status %0d: item with nothing expected", status_index);
		end else begin
			s = pending_status.pop_front();
			check_field("pump_on", 32'(s.pump_on), 32'(status_ch.pump_on));
			check_field("alarm_on", 32'(s.alarm_on), 32'(status_ch.alarm_on));
			check_field("phase", 32'(s.phase), 32'(status_ch.phase));
			check_field("remaining_seconds", 32'(s.secs), 32'(status_ch.remaining_seconds));
			check_field("stop_cause", 32'(s.cause), 32'(status_ch.stop_cause));
			check_field("pump_started", 32'(s.started), 32'(status_ch.pump_started));
			check_field("pump_stopped", 32'(s.stopped), 32'(status_ch.pump_stopped));
			check_field("fill_total_out", s.fills, status_ch.fill_total_out);
			check_field("alarm_total_out", s.alarms, status_ch.alarm_total_out);
		end
		status_index++;
	endtask

	task automatic test_fill_cycle();
		send_tick(32'd0, 1'b0, 1'b0);
		send_tick(32'd10, 1'b1, 1'b0);
		send_tick(32'd1000, 1'b0, 1'b0);
		send_tick(32'd300001, 1'b0, 1'b0);
		send_tick(32'd300002, 1'b1, 1'b0);
		send_tick(32'd300500, 1'b0, 1'b0);
		send_tick(32'd600499, 1'b0, 1'b0);
		send_tick(32'd600500, 1'b0, 1'b0);
	endtask

	task automatic test_deadline_wrap();
		send_tick(32'hFFFF_0000, 1'b1, 1'b0);
		send_tick(32'hFFFF_FFFF, 1'b0, 1'b0);
		send_tick(32'd0, 1'b0, 1'b0);
		send_tick(32'd299998, 1'b0, 1'b0);
		send_tick(32'd299999, 1'b0, 1'b0);
		// jump back in time, then to the edge of the signed window
		send_tick(32'd1000, 1'b1, 1'b0);
		send_tick(32'd2000, 1'b0, 1'b0);
		send_tick(32'd302000 - 32'd100000000, 1'b0, 1'b0);
		send_tick(32'd302000 + 32'h8000_0000, 1'b0, 1'b0);
		send_tick(32'd302000 + 32'h7FFF_FFFF, 1'b0, 1'b0);
	endtask

	task automatic test_alarm();
		send_tick(32'd5000, 1'b0, 1'b1);
		send_tick(32'd5001, 1'b1, 1'b1);
		send_tick(32'd5002, 1'b1, 1'b0);
		send_tick(32'd5003, 1'b0, 1'b0);
		send_tick(32'd5004, 1'b1, 1'b0);
		send_tick(32'd5005, 1'b1, 1'b1);
		send_tick(32'd5006, 1'b0, 1'b0);
		send_tick(32'd5007, 1'b1, 1'b0);
		send_tick(32'd5008, 1'b0, 1'b0);
		send_tick(32'd5009, 1'b0, 1'b1);
		send_tick(32'd5010, 1'b0, 1'b0);
	endtask

	task automatic test_random_fills(input logic [7:0] minutes);
		write_timeout(minutes);
		tick_time = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 20000000);
		repeat (RANDOM_TICKS) begin
			if ($urandom_range(0, 49) == 0) begin
				tx_eager = ($urandom_range(0, 3) == 0);
				rx_eager = ($urandom_range(0, 3) == 0);
			end
			random_tick();
		end
		tx_eager = 1'b0;
		rx_eager = 1'b0;
	endtask

	task automatic test_backpressure();
		rx_hold_cycles = RX_HOLD;
		tx_eager = 1'b1;
		repeat (40) random_tick();
		tx_eager = 1'b0;
	endtask

	initial begin
		logic [7:0] timeout_plan[8];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		tick_ch.valid = 1'b0;
		tick_ch.now_ms = '0;
		tick_ch.lower_wet = 1'b0;
		tick_ch.upper_wet = 1'b0;
		timeout_minutes = RESET_TIMEOUT_MINUTES;
		cur_phase = PH_STANDBY;
		pump_active = 1'b0;
		alarm_active = 1'b0;
		end_time_ms = '0;
		run_s = '0;
		left_s = '0;
		cause_q = CAUSE_NONE;
		fill_count = '0;
		alarm_count = '0;
		mismatch_count = 0;
		status_index = 0;
		rx_hold_cycles = 0;
		tx_eager = 1'b0;
		rx_eager = 1'b0;
		tick_time = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_fill_cycle();
		test_deadline_wrap();
		test_alarm();
		timeout_plan = '{8'd0, 8'd255, 8'd1, 8'd240, 8'd241, 8'd0, 8'd0, 8'd5};
		timeout_plan[5] = 8'($urandom_range(0, 255));
		timeout_plan[6] = 8'($urandom_range(2, 60));
		foreach (timeout_plan[i])
			test_random_fills(timeout_plan[i]);
		test_backpressure();

		drain_status();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_status.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int gap;
		status_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_hold_cycles > 0) begin
				gap = rx_hold_cycles;
				rx_hold_cycles = 0;
			end else begin
				gap = rx_eager ? 0 : $urandom_range(0, IDLE_MAX);
			end
			if (gap > 0) begin
				@(negedge clk);
				status_ch.ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			status_ch.ready <= 1'b1;
			do @(posedge clk); while (status_ch.valid !== 1'b1);
			check_status();
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((tick_ch.valid === 1'b1 && tick_ch.ready === 1'b1) ||
				(status_ch.valid === 1'b1 && status_ch.ready === 1'b1))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== pump_fill_level_controller.f =====
hw/rtl/pflc_pkg.sv
hw/rtl/pflc_tick_if.sv
hw/rtl/pflc_status_if.sv
hw/rtl/pflc_ctrl.sv
hw/rtl/pflc_secs.sv
hw/rtl/pump_fill_level_controller.sv
bench/tb_pump_fill_level_controller.sv
